/* design/bitmap_index_allocator_macros.svh */
// Assertion macros shared by the allocator RTL.
`ifndef BITMAP_INDEX_ALLOCATOR_MACROS_SVH
`define BITMAP_INDEX_ALLOCATOR_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define BIA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("bitmap_index_allocator: assertion failed");

// Condition must never be true outside reset.
`define BIA_ASSERT_NEVER(lbl, clk, rstn, cond) \
  `BIA_ASSERT(lbl, clk, rstn, !(cond))

`endif

/* design/bia_pkg.sv */
// Package: types and constants of the bitmap index allocator.
package bia_pkg;

  localparam int unsigned IDX_W      = 16;
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned BIT_W      = 6;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 2'd1;

  localparam logic [IDX_W-1:0] RANGE_LOW_RST  = 16'd0;
  localparam logic [IDX_W-1:0] RANGE_HIGH_RST = 16'd1023;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_QUERY = 2'd2
  } bia_func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NO_FREE = 2'd1,
    STATUS_RANGE   = 2'd2
  } bia_status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_INIT,
    S_IDLE,
    S_ALLOC,
    S_SCAN,
    S_WRAP,
    S_FREE,
    S_QUERY,
    S_DONE
  } bia_state_e;

  // Effective range after swap and clamp.
  typedef struct packed {
    logic [IDX_W-1:0] lo;
    logic [IDX_W:0]   hi;
    logic [IDX_W-1:0] span_m1;
  } bia_range_t;

endpackage

/* design/bia_if.sv */
// Request and response channel interfaces of the allocator.
interface bia_req_if;
  import bia_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [IDX_W-1:0]  slot_index;

  modport source (output valid, output func, output slot_index, input ready);
  modport sink   (input valid, input func, input slot_index, output ready);
endinterface

interface bia_rsp_if;
  import bia_pkg::*;
  logic                valid;
  logic                ready;
  logic [IDX_W-1:0]    granted_index;
  logic [STATUS_W-1:0] status;
  logic                is_used;

  modport source (output valid, output granted_index, output status, output is_used,
                  input ready);
  modport sink   (input valid, input granted_index, input status, input is_used,
                  output ready);
endinterface

/* design/bia_map_mem.sv */
// Used-bit map storage: one write port, one registered read port.
`include "bitmap_index_allocator_macros.svh"

module bia_map_mem #(
  parameter int unsigned WORDS = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic [AW-1:0]              rd_addr_i,
  output logic [bia_pkg::WORD_W-1:0] rd_data_o,
  input  logic                       we_i,
  input  logic [AW-1:0]              wr_addr_i,
  input  logic [bia_pkg::WORD_W-1:0] wr_data_i
);
  import bia_pkg::*;

  logic [WORD_W-1:0] mem_q [WORDS];
  logic [WORD_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

  // Controller keeps reads off the word it is writing back.
  `BIA_ASSERT_NEVER(a_no_rw_collision, clk_i, rst_ni, (rd_en_i && we_i && rd_addr_i == wr_addr_i))

endmodule

/* design/bia_ctrl.sv */
// Allocator sequencer: read-modify-write of the map and word-serial free-slot search.
`include "bitmap_index_allocator_macros.svh"

module bia_ctrl #(
  parameter int unsigned WORDS = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clear_i,
  input  bia_pkg::bia_range_t        rng_i,
  bia_req_if.sink                    req,
  bia_rsp_if.source                  rsp,
  output logic                       mem_rd_en_o,
  output logic [AW-1:0]              mem_rd_addr_o,
  input  logic [bia_pkg::WORD_W-1:0] mem_rd_data_i,
  output logic                       mem_we_o,
  output logic [AW-1:0]              mem_wr_addr_o,
  output logic [bia_pkg::WORD_W-1:0] mem_wr_data_o
);
  import bia_pkg::*;

  localparam logic [AW-1:0]     LAST_WORD = AW'(WORDS - 1);
  localparam logic [WORD_W-1:0] ONES      = '1;
  localparam logic [WORD_W-1:0] ONE       = WORD_W'(1);

  // Lowest set bit: {hit, position}.
  function automatic logic [BIT_W:0] first_set(input logic [WORD_W-1:0] v);
    logic [BIT_W:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = {1'b1, BIT_W'(i)};
      end
    end
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] span_mask(input logic [AW-1:0]    w,
                                                  input logic [AW-1:0]    lw,
                                                  input logic [BIT_W-1:0] lb);
    logic [WORD_W-1:0] m;
    m = ONES;
    if (w == lw) begin
      m = ONES >> (BIT_W'(WORD_W - 1) - lb);
    end
    return m;
  endfunction

  bia_state_e        state_q, state_d;
  logic [IDX_W-1:0]  hint_q, hint_d;
  logic              full_q, full_d;
  logic [AW-1:0]     sw_q, sw_d;
  logic [BIT_W-1:0]  sb_q, sb_d;
  logic [AW-1:0]     cur_q, cur_d;
  logic [WORD_W-1:0] sword_q, sword_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [IDX_W-1:0]  res_granted_q, res_granted_d;
  bia_status_e       res_status_q, res_status_d;
  logic              res_used_q, res_used_d;
  logic              out_valid_q, out_valid_d;
  logic [IDX_W-1:0]  out_granted_q, out_granted_d;
  bia_status_e       out_status_q, out_status_d;
  logic              out_used_q, out_used_d;

  logic [AW-1:0]     last_w;
  logic [BIT_W-1:0]  last_b;
  logic [IDX_W-1:0]  start_raw, start_off, req_off;
  logic              in_range, accept;
  logic [WORD_W-1:0] bit_sel, set_word, clr_word, cand_vec;
  logic [AW-1:0]     cand_word, nxt_word;
  logic [BIT_W:0]    fs;
  logic [IDX_W-1:0]  found_hint;

  assign last_w    = rng_i.span_m1[BIT_W +: AW];
  assign last_b    = rng_i.span_m1[BIT_W-1:0];
  assign start_raw = hint_q - rng_i.lo;
  assign start_off = (start_raw > rng_i.span_m1) ? '0 : start_raw;
  assign req_off   = req.slot_index - rng_i.lo;
  assign in_range  = (req.slot_index >= rng_i.lo) && ({1'b0, req.slot_index} <= rng_i.hi);

  assign req.ready = (state_q == S_IDLE) && !clear_i;
  assign accept    = req.valid && req.ready;

  assign bit_sel  = ONE << sb_q;
  assign set_word = mem_rd_data_i | bit_sel;
  assign clr_word = mem_rd_data_i & ~bit_sel;

  // One priority encoder serves the start word, the scanned words and the wrap check.
  always_comb begin
    case (state_q)
      S_ALLOC: begin
        cand_word = sw_q;
        cand_vec  = ~set_word & ((ONES << sb_q) << 1) & span_mask(sw_q, last_w, last_b);
      end
      S_WRAP: begin
        cand_word = sw_q;
        cand_vec  = ~sword_q & ~(ONES << sb_q);
      end
      default: begin
        cand_word = cur_q;
        cand_vec  = ~mem_rd_data_i & span_mask(cur_q, last_w, last_b);
      end
    endcase
  end

  assign fs         = first_set(cand_vec);
  assign nxt_word   = (cand_word == last_w) ? '0 : cand_word + 1'b1;
  assign found_hint = rng_i.lo + IDX_W'({cand_word, fs[BIT_W-1:0]});

  always_comb begin
    state_d       = state_q;
    hint_d        = hint_q;
    full_d        = full_q;
    sw_d          = sw_q;
    sb_d          = sb_q;
    cur_d         = cur_q;
    sword_d       = sword_q;
    clr_d         = clr_q;
    res_granted_d = res_granted_q;
    res_status_d  = res_status_q;
    res_used_d    = res_used_q;
    out_valid_d   = out_valid_q && !rsp.ready;
    out_granted_d = out_granted_q;
    out_status_d  = out_status_q;
    out_used_d    = out_used_q;
    mem_rd_en_o   = 1'b0;
    mem_rd_addr_o = cur_q;
    mem_we_o      = 1'b0;
    mem_wr_addr_o = cur_q;
    mem_wr_data_o = clr_word;

    case (state_q)
      S_CLEAR: begin
        mem_we_o      = 1'b1;
        mem_wr_addr_o = clr_q;
        mem_wr_data_o = '0;
        if (clr_q == LAST_WORD) begin
          state_d = S_INIT;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      S_INIT: begin
        hint_d  = rng_i.lo;
        full_d  = 1'b0;
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          res_granted_d = '0;
          res_status_d  = STATUS_OK;
          res_used_d    = 1'b0;
          state_d       = S_DONE;
          case (bia_func_e'(req.func))
            FUNC_ALLOC: begin
              if (full_q) begin
                res_status_d = STATUS_NO_FREE;
              end else begin
                res_granted_d = rng_i.lo + start_off;
                sw_d          = start_off[BIT_W +: AW];
                sb_d          = start_off[BIT_W-1:0];
                mem_rd_en_o   = 1'b1;
                mem_rd_addr_o = start_off[BIT_W +: AW];
                state_d       = S_ALLOC;
              end
            end
            FUNC_FREE: begin
              if (!in_range) begin
                res_status_d = STATUS_RANGE;
              end else begin
                cur_d         = req_off[BIT_W +: AW];
                sb_d          = req_off[BIT_W-1:0];
                mem_rd_en_o   = 1'b1;
                mem_rd_addr_o = req_off[BIT_W +: AW];
                if (req.slot_index < hint_q || full_q) begin
                  hint_d = req.slot_index;
                  full_d = 1'b0;
                end
                state_d = S_FREE;
              end
            end
            FUNC_QUERY: begin
              if (!in_range) begin
                res_status_d = STATUS_RANGE;
              end else begin
                cur_d         = req_off[BIT_W +: AW];
                sb_d          = req_off[BIT_W-1:0];
                mem_rd_en_o   = 1'b1;
                mem_rd_addr_o = req_off[BIT_W +: AW];
                state_d       = S_QUERY;
              end
            end
            default: begin
              res_status_d = STATUS_RANGE;
            end
          endcase
        end
      end
      S_ALLOC, S_SCAN: begin
        if (state_q == S_ALLOC) begin
          mem_we_o      = 1'b1;
          mem_wr_addr_o = sw_q;
          mem_wr_data_o = set_word;
          sword_d       = set_word;
        end
        if (fs[BIT_W]) begin
          hint_d  = found_hint;
          state_d = S_DONE;
        end else if (nxt_word == sw_q) begin
          state_d = S_WRAP;
        end else begin
          mem_rd_en_o   = 1'b1;
          mem_rd_addr_o = nxt_word;
          cur_d         = nxt_word;
          state_d       = S_SCAN;
        end
      end
      S_WRAP: begin
        if (fs[BIT_W]) begin
          hint_d = found_hint;
        end else begin
          full_d = 1'b1;
        end
        state_d = S_DONE;
      end
      S_FREE: begin
        mem_we_o = 1'b1;
        state_d  = S_DONE;
      end
      S_QUERY: begin
        res_used_d = mem_rd_data_i[sb_q];
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || rsp.ready) begin
          out_valid_d   = 1'b1;
          out_granted_d = res_granted_q;
          out_status_d  = res_status_q;
          out_used_d    = res_used_q;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (clear_i) begin
      state_d = S_CLEAR;
      clr_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      hint_q      <= '0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      hint_q      <= hint_d;
      full_q      <= full_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sw_q          <= sw_d;
    sb_q          <= sb_d;
    cur_q         <= cur_d;
    sword_q       <= sword_d;
    res_granted_q <= res_granted_d;
    res_status_q  <= res_status_d;
    res_used_q    <= res_used_d;
    out_granted_q <= out_granted_d;
    out_status_q  <= out_status_d;
    out_used_q    <= out_used_d;
  end

  assign rsp.valid         = out_valid_q;
  assign rsp.granted_index = out_granted_q;
  assign rsp.status        = out_status_q;
  assign rsp.is_used       = out_used_q;

  `BIA_ASSERT(a_hint_in_range, clk_i, rst_ni, (state_q == S_IDLE) |-> (hint_q >= rng_i.lo && {1'b0, hint_q} <= rng_i.hi))
  `BIA_ASSERT(a_scan_skips_start, clk_i, rst_ni, (state_q == S_SCAN) |-> (cur_q != sw_q))
  `BIA_ASSERT(a_search_not_full, clk_i, rst_ni, (state_q == S_ALLOC || state_q == S_SCAN || state_q == S_WRAP) |-> !full_q)

endmodule

/* design/bitmap_index_allocator.sv */
// Bitmap index allocator: next-fit index allocation over a used-bit map in block RAM.
//
// Hands out indexes in [lo, hi], lo and hi being the smaller and larger of the two
// bound registers, the span clamped to MAX_SLOTS. The used-bit map lives in a RAM of
// ceil(MAX_SLOTS/64) words of 64 bits. Allocate grants the hint, sets its bit, then
// scans forward one map word per cycle (wrapping to lo) for the next free slot, which
// becomes the hint; if none exists the full mark is set. Free clears a bit and pulls
// the hint back to it when it lies below the hint or the map was full. Query returns
// the bit. Allocate reads the start word, writes it back with the bit set, then
// reads further words until it finds a free slot or comes back to the start
// word; free and query read the word, then write it back or test the bit, then
// post the result; errors and allocate-while-full post the result directly.
// The response sits in an output register, so a new request is taken while the
// last response waits. After reset and after each write to a bound register the
// map RAM is swept clear, one word per cycle, and the hint reloaded; all that
// time req_chan.ready stays low. Writes to unused register indexes are ignored.
// Configure only while no request is in flight.
module bitmap_index_allocator #(
  parameter int unsigned MAX_SLOTS = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bia_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bia_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  bia_req_if.sink                        req_chan,
  bia_rsp_if.source                      rsp_chan
);
  import bia_pkg::*;

  localparam int unsigned WORDS  = (MAX_SLOTS + WORD_W - 1) / WORD_W;
  localparam int unsigned AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned SPAN_W = IDX_W + 1;
  localparam logic [SPAN_W-1:0] MAX_SPAN_M1 = SPAN_W'(MAX_SLOTS - 1);

  logic [IDX_W-1:0] range_low_q, range_high_q;
  logic             wr_low, wr_high, clear;
  logic [IDX_W-1:0] lo_min, hi_max, diff, span_m1;
  bia_range_t       rng_d, rng_q;

  logic              mem_rd_en, mem_we;
  logic [AW-1:0]     mem_rd_addr, mem_wr_addr;
  logic [WORD_W-1:0] mem_rd_data, mem_wr_data;

  // Bound registers; any bound write restarts the map clear.
  assign wr_low  = cfg_we_i && (cfg_idx_i == REG_RANGE_LOW);
  assign wr_high = cfg_we_i && (cfg_idx_i == REG_RANGE_HIGH);
  assign clear   = wr_low || wr_high;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q  <= RANGE_LOW_RST;
      range_high_q <= RANGE_HIGH_RST;
    end else begin
      if (wr_low) begin
        range_low_q <= cfg_wdata_i;
      end
      if (wr_high) begin
        range_high_q <= cfg_wdata_i;
      end
    end
  end

  // Swap reversed bounds, clamp span to the map size.
  assign lo_min  = (range_low_q < range_high_q) ? range_low_q : range_high_q;
  assign hi_max  = (range_low_q < range_high_q) ? range_high_q : range_low_q;
  assign diff    = hi_max - lo_min;
  assign span_m1 = ({1'b0, diff} > MAX_SPAN_M1) ? MAX_SPAN_M1[IDX_W-1:0] : diff;

  always_comb begin
    rng_d.lo      = lo_min;
    rng_d.span_m1 = span_m1;
    rng_d.hi      = {1'b0, lo_min} + {1'b0, span_m1};
  end

  // Bounds only move under a clear sweep, so a registered copy is safe.
  always_ff @(posedge clk_i) begin
    rng_q <= rng_d;
  end

  bia_ctrl #(
    .WORDS (WORDS),
    .AW    (AW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clear_i       (clear),
    .rng_i         (rng_q),
    .req           (req_chan),
    .rsp           (rsp_chan),
    .mem_rd_en_o   (mem_rd_en),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_rd_data_i (mem_rd_data),
    .mem_we_o      (mem_we),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data)
  );

  bia_map_mem #(
    .WORDS (WORDS),
    .AW    (AW)
  ) u_map_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data),
    .we_i      (mem_we),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data)
  );

endmodule

/* tb/sv/allocator_checker.sv */
// Checker for the bitmap index allocator: predicts each reply and compares it.
module allocator_checker
  import bia_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  bia_req_if                    req_chan,
  bia_rsp_if                    rsp_chan,
  output int                    error_count_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [IDX_W-1:0] granted;
    bia_status_e      status;
    logic             used;
  } reply_t;

  // Shadow copy of the allocator: bound registers, used map, hint, full mark.
  logic [IDX_W-1:0] bound_low;
  logic [IDX_W-1:0] bound_high;
  logic [IDX_W-1:0] next_hint;
  logic             map_full;
  logic             slot_used [MAX_SLOTS];
  reply_t           expected_replies [$];

  function automatic int unsigned range_lo();
    return (bound_low < bound_high) ? bound_low : bound_high;
  endfunction

  // Slot count after swap and clamp.
  function automatic int unsigned range_span();
    int unsigned lo;
    int unsigned hi;
    lo = range_lo();
    hi = (bound_low < bound_high) ? bound_high : bound_low;
    return (hi - lo + 1 > MAX_SLOTS) ? MAX_SLOTS : hi - lo + 1;
  endfunction

  function automatic void clear_map();
    foreach (slot_used[k]) slot_used[k] = 1'b0;
    next_hint = IDX_W'(range_lo());
    map_full  = 1'b0;
  endfunction

  // Applies one request to the shadow state and returns the reply it causes.
  function automatic reply_t serve_request(logic [FUNC_W-1:0] func, logic [IDX_W-1:0] slot);
    reply_t           r;
    int unsigned      lo;
    int unsigned      span;
    int unsigned      start;
    int unsigned      pos;
    int unsigned      k;
    logic [IDX_W-1:0] offset;
    logic             found;
    r.granted = '0;
    r.status  = STATUS_OK;
    r.used    = 1'b0;
    lo   = range_lo();
    span = range_span();
    case (func)
      FUNC_ALLOC: begin
        if (map_full) begin
          r.status = STATUS_NO_FREE;
        end else begin
          offset    = next_hint - IDX_W'(lo);
          start     = (offset >= span) ? 0 : offset;
          r.granted = IDX_W'(lo + start);
          slot_used[start] = 1'b1;
          // next-fit: walk forward with wrap for the next clear bit
          pos   = start;
          found = 1'b0;
          for (k = 1; k < span && !found; k++) begin
            pos   = (pos + 1 == span) ? 0 : pos + 1;
            found = !slot_used[pos];
          end
          if (found) next_hint = IDX_W'(lo + pos);
          else       map_full  = 1'b1;
        end
      end
      FUNC_FREE: begin
        if (slot < lo || slot > lo + span - 1) begin
          r.status = STATUS_RANGE;
        end else begin
          slot_used[slot - lo] = 1'b0;
          if (slot < next_hint || map_full) begin
            next_hint = slot;
            map_full  = 1'b0;
          end
        end
      end
      FUNC_QUERY: begin
        if (slot < lo || slot > lo + span - 1) r.status = STATUS_RANGE;
        else                                   r.used   = slot_used[slot - lo];
      end
      default: r.status = STATUS_RANGE;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    if (!rst_ni) begin
      bound_low  = RANGE_LOW_RST;
      bound_high = RANGE_HIGH_RST;
      clear_map();
      expected_replies.delete();
      error_count_o = 0;
    end else begin
      // reply first: a request taken at this edge cannot be answered at it
      if (rsp_chan.valid && rsp_chan.ready) begin
        if (expected_replies.size() == 0) begin
          error_count_o++;
          if (error_count_o <= REPORT_LIMIT)
            $display("%t: reply with none expected: granted %0d status %0d used %0d",
                     $realtime, rsp_chan.granted_index, rsp_chan.status, rsp_chan.is_used);
        end else begin
          want = expected_replies.pop_front();
          if (rsp_chan.granted_index !== want.granted || rsp_chan.status !== want.status ||
              rsp_chan.is_used !== want.used) begin
            error_count_o++;
            if (error_count_o <= REPORT_LIMIT)
              $display({"%t: reply mismatch: expected granted %0d status %0d used %0d,",
                        " got granted %0d status %0d used %0d"},
                       $realtime, want.granted, want.status, want.used,
                       rsp_chan.granted_index, rsp_chan.status, rsp_chan.is_used);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_RANGE_LOW: begin
            bound_low = cfg_wdata_i;
            clear_map();
          end
          REG_RANGE_HIGH: begin
            bound_high = cfg_wdata_i;
            clear_map();
          end
          default: ;
        endcase
      end
      if (req_chan.valid && req_chan.ready)
        expected_replies.push_back(serve_request(req_chan.func, req_chan.slot_index));
    end
    pending_o = expected_replies.size();
  end

endmodule

/* tb/sv/tb_top.sv */
// Testbench top: stimulus, handshake pacing and verdict for the bitmap index allocator.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bia_pkg::*;

  localparam int unsigned MAX_SLOTS     = 1024;
  localparam int unsigned MAP_WORDS     = (MAX_SLOTS + WORD_W - 1) / WORD_W;
  // Long enough for the worst allocate scan and for the clear sweep.
  localparam int unsigned SETTLE_CYCLES = MAP_WORDS + 8;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned RANDOM_PHASES = 14;
  localparam int unsigned PHASE_BEATS   = 138;
  // Fill and drain bursts alternate inside a phase, this many beats each.
  localparam int unsigned BURST_BEATS   = 40;

  // Codes outside the package lists: unused func code and an unmapped register.
  localparam logic [FUNC_W-1:0]    FUNC_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 2'd2;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  int                    error_count;
  int                    replies_pending;
  int unsigned           cycle_count = 0;

  // Current effective range (after swap and clamp), used to aim free/query indexes.
  int unsigned range_base;
  int unsigned range_size;

  // Set by the stimulus to make the reply side hold off for a long stretch.
  bit hold_replies = 1'b0;
  // Set by the reply side once that hold-off is over.
  bit hold_done    = 1'b0;
  // Cleared for phases where the sender offers back-to-back beats.
  bit tx_gaps_on   = 1'b1;

  bia_req_if req_chan ();
  bia_rsp_if rsp_chan ();

  bitmap_index_allocator #(
    .MAX_SLOTS (MAX_SLOTS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_chan    (req_chan),
    .rsp_chan    (rsp_chan)
  );

  allocator_checker #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .req_chan      (req_chan),
    .rsp_chan      (rsp_chan),
    .error_count_o (error_count),
    .pending_o     (replies_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Mostly short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offers one request beat and holds it until taken. Valid stays up when no
  // gap follows, so back-to-back beats never lower and raise it in one step.
  task automatic send_request(input logic [FUNC_W-1:0] func, input logic [IDX_W-1:0] slot);
    int unsigned gap;
    req_chan.valid      <= 1'b1;
    req_chan.func       <= func;
    req_chan.slot_index <= slot;
    do @(posedge clk_i); while (!req_chan.ready);
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      req_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stops offering and waits until every predicted reply has come back.
  task automatic wait_drained();
    req_chan.valid <= 1'b0;
    @(posedge clk_i);
    while (replies_pending != 0) @(posedge clk_i);
  endtask

  // Register write on an idle block; the pause covers the clear sweep of a
  // previous write.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_range(input logic [IDX_W-1:0] low, input logic [IDX_W-1:0] high);
    int unsigned lo;
    int unsigned hi;
    wait_drained();
    write_register(REG_RANGE_LOW, low);
    write_register(REG_RANGE_HIGH, high);
    lo = (low < high) ? low : high;
    hi = (low < high) ? high : low;
    range_base = lo;
    range_size = (hi - lo + 1 > MAX_SLOTS) ? MAX_SLOTS : hi - lo + 1;
  endtask

  // New bounds for a random phase: mostly small spans so the map fills and
  // wraps, some at the ends of the index space, some wide enough to clamp.
  task automatic pick_random_range();
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    int unsigned      size;
    case ($urandom_range(0, 9))
      0: begin
        a = IDX_W'($urandom);
        b = IDX_W'($urandom);
      end
      1: begin
        a = '1;
        b = a - IDX_W'($urandom_range(0, 40));
      end
      2: begin
        a = '0;
        b = IDX_W'($urandom_range(0, 40));
      end
      default: begin
        size = ($urandom_range(0, 4) == 0) ? $urandom_range(49, 300) : $urandom_range(1, 48);
        a    = IDX_W'($urandom_range(0, 65536 - size));
        b    = a + IDX_W'(size - 1);
      end
    endcase
    // either order; the block swaps reversed bounds
    if ($urandom_range(0, 1) == 1) set_range(b, a);
    else                           set_range(a, b);
  endtask

  // One random beat. Indexes mostly land in range, some just outside it and
  // some anywhere in the 16-bit space.
  task automatic send_random(input int unsigned alloc_pct);
    int unsigned       roll;
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  slot;
    roll = $urandom_range(0, 99);
    if (roll < 2)                              func = FUNC_UNUSED;
    else if ($urandom_range(0, 99) < alloc_pct) func = FUNC_ALLOC;
    else if ($urandom_range(0, 4) < 3)         func = FUNC_FREE;
    else                                       func = FUNC_QUERY;
    roll = $urandom_range(0, 99);
    if (roll < 80)
      slot = IDX_W'(range_base + $urandom_range(0, range_size - 1));
    else if (roll < 88)
      slot = ($urandom_range(0, 1) == 1) ? IDX_W'(range_base - 1)
                                         : IDX_W'(range_base + range_size);
    else
      slot = IDX_W'($urandom);
    send_request(func, slot);
  endtask

  // Reply side: ready runs of random length broken by random stalls, plus one
  // long hold-off on request so the block backs up into its request port.
  initial begin
    int unsigned run;
    int unsigned gap;
    rsp_chan.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_replies && !hold_done) begin
        rsp_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        run = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
        rsp_chan.ready <= 1'b1;
        repeat (run) @(posedge clk_i);
        gap = pick_gap();
        if (gap > 0) begin
          rsp_chan.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("bitmap_index_allocator test failed");
    $finish;
  end

  initial begin
    int unsigned phase;
    int unsigned n;
    req_chan.valid      <= 1'b0;
    req_chan.func       <= FUNC_ALLOC;
    req_chan.slot_index <= '0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= REG_RANGE_LOW;
    cfg_wdata_i         <= '0;
    range_base = RANGE_LOW_RST;
    range_size = RANGE_HIGH_RST - RANGE_LOW_RST + 1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed: default range 0..1023 ---
    send_request(FUNC_ALLOC, '0);         // grants 0
    send_request(FUNC_ALLOC, '1);         // grants 1, index field ignored
    send_request(FUNC_QUERY, 16'd0);      // used
    send_request(FUNC_QUERY, 16'd1024);   // one past the top
    send_request(FUNC_FREE,  16'd0);      // below hint: hint pulled back
    send_request(FUNC_ALLOC, '0);         // grants 0 again
    send_request(FUNC_FREE,  16'd700);    // slot never used, above hint
    send_request(FUNC_FREE,  16'hFFFF);   // out of range
    send_request(FUNC_UNUSED, 16'hFFFF);  // unused func code

    // single-slot range: first allocate fills the map
    set_range(16'd5, 16'd5);
    send_request(FUNC_ALLOC, '0);         // grants 5, full
    send_request(FUNC_ALLOC, '0);         // no free slot
    send_request(FUNC_QUERY, 16'd5);
    send_request(FUNC_FREE,  16'd5);      // full: hint back, full cleared
    send_request(FUNC_ALLOC, '0);         // grants 5 again
    send_request(FUNC_QUERY, 16'd4);      // below range
    send_request(FUNC_FREE,  16'd6);      // above range

    // reversed bounds at the top of the index space
    set_range(16'hFFFF, 16'hFFF0);
    send_request(FUNC_ALLOC, '0);         // grants FFF0
    send_request(FUNC_QUERY, 16'hFFFF);
    send_request(FUNC_FREE,  16'hFFF0);

    // widest bounds: span clamped to MAX_SLOTS
    set_range(16'h0000, 16'hFFFF);
    send_request(FUNC_ALLOC, '0);         // grants 0
    send_request(FUNC_QUERY, 16'd1024);   // past the clamp

    // write to an unmapped register index must leave the map alone
    wait_drained();
    write_register(REG_SPARE, 16'hA5A5);
    send_request(FUNC_QUERY, 16'd0);      // still used

    // --- random phases ---
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      pick_random_range();
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      for (n = 0; n < PHASE_BEATS; n++) begin
        // long reply hold-off while requests keep coming
        if (phase == 0 && n == 10) hold_replies = 1'b1;
        // sender pause until everything outstanding is back
        if (phase == RANDOM_PHASES / 2 && n == PHASE_BEATS / 2) wait_drained();
        send_random(((n / BURST_BEATS) % 2 == 0) ? 85 : 30);
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0 && replies_pending == 0)
      $display("bitmap_index_allocator test passed");
    else
      $display("bitmap_index_allocator test failed");
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/bia_pkg.sv
design/bia_if.sv
design/bia_map_mem.sv
design/bia_ctrl.sv
design/bitmap_index_allocator.sv
tb/sv/allocator_checker.sv
tb/sv/tb_top.sv
